// File: rtl/caw_pkg.sv
// Package for the charge assignment weight unit: polynomial coefficient
// table, divisor decomposition, register index and shared constants.
// No dependencies.
package caw_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int MAX_ORDER         = 7;
    localparam int COEF_W            = 16;

    localparam logic       REG_ASSIGN_ORDER   = 1'b0;
    localparam logic [2:0] ASSIGN_ORDER_RESET = 3'd1;

    typedef enum logic [1:0] {
        ODD_1,
        ODD_3,
        ODD_15,
        ODD_45
    } odd_t;

    typedef struct packed {
        logic [3:0]  shift;
        odd_t        odd;
        logic [15:0] half;
    } div_info_t;

    // [order-1][point][degree], lowest degree first
    localparam int PolyTab [7][7][7] = '{
        '{ '{1, 0, 0, 0, 0, 0, 0}, '{default: 0}, '{default: 0}, '{default: 0},
           '{default: 0}, '{default: 0}, '{default: 0} },
        '{ '{1, -2, 0, 0, 0, 0, 0}, '{1, 2, 0, 0, 0, 0, 0}, '{default: 0},
           '{default: 0}, '{default: 0}, '{default: 0}, '{default: 0} },
        '{ '{1, -4, 4, 0, 0, 0, 0}, '{6, 0, -8, 0, 0, 0, 0}, '{1, 4, 4, 0, 0, 0, 0},
           '{default: 0}, '{default: 0}, '{default: 0}, '{default: 0} },
        '{ '{1, -6, 12, -8, 0, 0, 0}, '{23, -30, -12, 24, 0, 0, 0},
           '{23, 30, -12, -24, 0, 0, 0}, '{1, 6, 12, 8, 0, 0, 0},
           '{default: 0}, '{default: 0}, '{default: 0} },
        '{ '{1, -8, 24, -32, 16, 0, 0}, '{19, -44, 24, 16, -16, 0, 0},
           '{115, 0, -120, 0, 48, 0, 0}, '{19, 44, 24, -16, -16, 0, 0},
           '{1, 8, 24, 32, 16, 0, 0}, '{default: 0}, '{default: 0} },
        '{ '{1, -10, 40, -80, 80, -32, 0}, '{237, -750, 840, -240, -240, 160, 0},
           '{841, -770, -440, 560, 80, -160, 0}, '{841, 770, -440, -560, 80, 160, 0},
           '{237, 750, 840, 240, -240, -160, 0}, '{1, 10, 40, 80, 80, 32, 0},
           '{default: 0} },
        '{ '{1, -12, 60, -160, 240, -192, 64},
           '{361, -1416, 2220, -1600, 240, 384, -192},
           '{10543, -17340, 4740, 6880, -4080, -960, 960},
           '{5887, 0, -4620, 0, 1680, 0, -320},
           '{10543, 17340, 4740, -6880, -4080, 960, 960},
           '{361, 1416, 2220, 1600, 240, -384, -192},
           '{1, 12, 60, 160, 240, 192, 64} }
    };

    function automatic logic signed [COEF_W-1:0] poly_coef(
        input logic [2:0] ord,
        input logic [2:0] idx,
        input logic [2:0] k
    );
        logic [2:0] row;
        row = 3'(ord - 3'd1);
        if (ord == 3'd0 || idx == 3'd7 || k == 3'd7) begin
            return '0;
        end
        return COEF_W'(PolyTab[row][idx][k]);
    endfunction

    // divisor = 2^shift * odd factor; half = floor(divisor / 2)
    function automatic div_info_t div_info(
        input logic [2:0] ord,
        input logic [2:0] idx
    );
        div_info_t di;
        di = '{shift: 4'd0, odd: ODD_1, half: 16'd0};
        case (ord)
            3'd2: di = '{shift: 4'd1, odd: ODD_1, half: 16'd1};
            3'd3: di = '{shift: 4'd3, odd: ODD_1, half: 16'd4};
            3'd4: di = '{shift: 4'd4, odd: ODD_3, half: 16'd24};
            3'd5: begin
                case (idx) inside
                    3'd0, 3'd4: di = '{shift: 4'd7, odd: ODD_3, half: 16'd192};
                    3'd1, 3'd3: di = '{shift: 4'd5, odd: ODD_3, half: 16'd48};
                    default:    di = '{shift: 4'd6, odd: ODD_3, half: 16'd96};
                endcase
            end
            3'd6: begin
                case (idx) inside
                    3'd2, 3'd3: di = '{shift: 4'd7, odd: ODD_15, half: 16'd960};
                    default:    di = '{shift: 4'd8, odd: ODD_15, half: 16'd1920};
                endcase
            end
            3'd7: begin
                case (idx) inside
                    3'd1, 3'd5: di = '{shift: 4'd9, odd: ODD_45, half: 16'd11520};
                    3'd3:       di = '{shift: 4'd8, odd: ODD_45, half: 16'd5760};
                    default:    di = '{shift: 4'd10, odd: ODD_45, half: 16'd23040};
                endcase
            end
            default: di = '{shift: 4'd0, odd: ODD_1, half: 16'd0};
        endcase
        return di;
    endfunction

endpackage

// File: rtl/charge_assignment_weight_unit.sv
// Charge assignment weight unit: pipelined evaluation of the P3M assignment
// polynomial for orders 1 to 7 with rounding and saturation.
// Depends on caw_pkg.

// The unit takes one request per clock while the output side does not stall
// and returns one weight per request, in order. The pipeline has one input
// stage that clamps the offset, seven Horner multiply-add stages (one per
// polynomial degree) and two scaling stages that divide by the stencil
// point's constant divisor through a reciprocal multiply. Stalls on the
// output collapse bubbles stage by stage, so requests keep entering while a
// finished weight waits. The order register sits at byte address 0 of the
// APB port; the user must write it only while the unit is idle, and the unit
// itself does not enforce this. An index at or above the order returns
// weight 0 with index_error set.
module charge_assignment_weight_unit
    import caw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // [2:0] point_index, [FRAC_BITS+3:3] offset, zero pad above
    input  logic [((FRAC_BITS + 11) / 8) * 8 - 1:0] s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [FRAC_BITS:0] weight, [FRAC_BITS+1] index_error, zero pad above
    output logic [((FRAC_BITS + 9) / 8) * 8 - 1:0]  m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int XW    = FRAC_BITS + 1;
    localparam int ACC_W = FRAC_BITS + 17;
    localparam int PW    = XW + ACC_W;
    localparam int NW    = FRAC_BITS + 6;
    localparam int RP    = NW + 6;
    localparam int RW    = RP + 1;
    localparam int NS    = 10;
    localparam int MW    = ((FRAC_BITS + 9) / 8) * 8;

    localparam logic signed [XW-1:0] HALF_X  = signed'(XW'(1) << (FRAC_BITS - 1));
    localparam logic [XW-1:0]        ONE_FX  = XW'(1) << FRAC_BITS;
    localparam logic signed [PW-1:0] RND_POS = signed'(PW'(1) << (FRAC_BITS - 1));
    localparam logic signed [PW-1:0] RND_NEG = RND_POS - PW'(1);

    localparam logic [NW-1:0] CAP1  = NW'((64'd1 << FRAC_BITS) + 64'd1);
    localparam logic [NW-1:0] CAP3  = NW'(64'd3 * ((64'd1 << FRAC_BITS) + 64'd1));
    localparam logic [NW-1:0] CAP15 = NW'(64'd15 * ((64'd1 << FRAC_BITS) + 64'd1));
    localparam logic [NW-1:0] CAP45 = NW'(64'd45 * ((64'd1 << FRAC_BITS) + 64'd1));
    localparam logic [RW-1:0] REC1  = RW'(64'd1 << RP);
    localparam logic [RW-1:0] REC3  = RW'(((64'd1 << RP) + 64'd2) / 64'd3);
    localparam logic [RW-1:0] REC15 = RW'(((64'd1 << RP) + 64'd14) / 64'd15);
    localparam logic [RW-1:0] REC45 = RW'(((64'd1 << RP) + 64'd44) / 64'd45);

    typedef struct packed {
        logic                    err;
        logic [2:0]              ord;
        logic [2:0]              idx;
        logic signed [XW-1:0]    x;
        logic signed [ACC_W-1:0] acc;
    } horner_t;

    typedef struct packed {
        logic          err;
        logic          zero;
        odd_t          odd;
        logic [NW-1:0] nq;
    } scale_t;

    typedef struct packed {
        logic          err;
        logic [XW-1:0] weight;
    } out_t;

    logic [2:0]       assign_order_reg;
    logic [0:NS-1]    vld_reg;
    logic [0:NS]      rdy;
    horner_t          hp_reg  [0:7];
    horner_t          hp_next [0:7];
    scale_t           dv_reg;
    scale_t           dv_next;
    out_t             out_reg;
    out_t             out_next;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ASSIGN_ORDER) ? 32'(assign_order_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            assign_order_reg <= ASSIGN_ORDER_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_ASSIGN_ORDER) begin
            assign_order_reg <= pwdata[2:0];
        end
    end

    // flow control: a stage loads when empty or when its successor moves
    always_comb begin
        rdy[NS] = m_tready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // input stage: clamp offset, flag bad index
    logic [2:0]           in_idx;
    logic signed [XW-1:0] in_x;

    assign in_idx = s_tdata[2:0];
    assign in_x   = signed'(s_tdata[3 +: XW]);

    always_comb begin
        hp_next[0].ord = assign_order_reg;
        hp_next[0].idx = in_idx;
        hp_next[0].err = (assign_order_reg == 3'd0)
                      || (32'(assign_order_reg) > MAX_ORDER)
                      || (in_idx >= assign_order_reg);
        if (in_x > HALF_X) begin
            hp_next[0].x = HALF_X;
        end else if (in_x < -HALF_X) begin
            hp_next[0].x = -HALF_X;
        end else begin
            hp_next[0].x = in_x;
        end
        hp_next[0].acc = '0;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            hp_reg[0] <= hp_next[0];
        end
    end

    // Horner stages, highest degree first
    for (genvar j = 1; j <= 7; j++) begin : g_horner
        localparam logic [2:0] K = 3'(7 - j);
        logic signed [XW-1:0]     xs;
        logic signed [ACC_W-1:0]  as;
        logic signed [PW-1:0]     prod;
        logic signed [PW-1:0]     rnd;
        logic signed [COEF_W-1:0] coef;

        assign xs   = hp_reg[j-1].x;
        assign as   = hp_reg[j-1].acc;
        assign coef = poly_coef(hp_reg[j-1].ord, hp_reg[j-1].idx, K);

        always_comb begin
            prod = PW'(xs) * PW'(as);
            rnd  = prod + (prod[PW-1] ? RND_NEG : RND_POS);
            hp_next[j]     = hp_reg[j-1];
            hp_next[j].acc = (ACC_W'(coef) <<< FRAC_BITS) + ACC_W'(rnd >>> FRAC_BITS);
        end

        always_ff @(posedge aclk) begin
            if (rdy[j]) begin
                hp_reg[j] <= hp_next[j];
            end
        end
    end

    // scaling stage one: add half divisor, drop power of two, cap
    div_info_t        di;
    logic [ACC_W-1:0] num;
    logic [ACC_W-1:0] nsh;
    logic [NW-1:0]    cap;

    always_comb begin
        di  = div_info(hp_reg[7].ord, hp_reg[7].idx);
        num = unsigned'(hp_reg[7].acc) + ACC_W'(di.half);
        nsh = num >> di.shift;
        case (di.odd)
            ODD_1:   cap = CAP1;
            ODD_3:   cap = CAP3;
            ODD_15:  cap = CAP15;
            ODD_45:  cap = CAP45;
            default: cap = CAP1;
        endcase
        dv_next.err  = hp_reg[7].err;
        dv_next.zero = hp_reg[7].acc[ACC_W-1] || (hp_reg[7].acc == '0);
        dv_next.odd  = di.odd;
        dv_next.nq   = (nsh >= ACC_W'(cap)) ? cap : NW'(nsh);
    end

    always_ff @(posedge aclk) begin
        if (rdy[8]) begin
            dv_reg <= dv_next;
        end
    end

    // scaling stage two: reciprocal multiply, saturate
    logic [RW-1:0]    rec;
    logic [NW+RW-1:0] qprod;
    logic [NW:0]      quot;

    always_comb begin
        case (dv_reg.odd)
            ODD_1:   rec = REC1;
            ODD_3:   rec = REC3;
            ODD_15:  rec = REC15;
            ODD_45:  rec = REC45;
            default: rec = REC1;
        endcase
        qprod = (NW+RW)'(dv_reg.nq) * (NW+RW)'(rec);
        quot  = qprod[RP +: NW+1];
        out_next.err = dv_reg.err;
        if (dv_reg.err || dv_reg.zero) begin
            out_next.weight = '0;
        end else if (quot > (NW+1)'(ONE_FX)) begin
            out_next.weight = ONE_FX;
        end else begin
            out_next.weight = XW'(quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[9]) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = MW'({out_reg.err, out_reg.weight});

    a_weight_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_reg.weight <= ONE_FX)
        else $error("weight above full scale");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.err |-> out_reg.weight == '0)
        else $error("index error with nonzero weight");

    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted request not held in input stage");

    a_lead_coef: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] |-> hp_reg[1].acc ==
            (ACC_W'(poly_coef(hp_reg[1].ord, hp_reg[1].idx, 3'd6)) <<< FRAC_BITS))
        else $error("first Horner stage does not hold leading coefficient");

    a_nonpos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[8] && dv_reg.zero && rdy[9] |=> out_reg.weight == '0)
        else $error("nonpositive polynomial value gave nonzero weight");

endmodule

// File: tb/charge_assignment_weight_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for charge_assignment_weight_unit: predicts every weight
// at request acceptance and compares results in order, under random gaps and stalls.
// Depends on caw_pkg and the unit itself.
module charge_assignment_weight_unit_tb;
    import caw_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEFAULT;
    localparam int SW        = ((FRAC + 11) / 8) * 8;
    localparam int MW        = ((FRAC + 9) / 8) * 8;
    localparam int PHASE_LEN = 128;
    localparam int TAIL      = 14;
    localparam longint CYCLE_LIMIT = 600000;
    localparam logic [2:0] ORDER_ADDR = 3'(4 * REG_ASSIGN_ORDER);

    // [order-1][point][degree], lowest degree first
    localparam int CoefRows [7][7][7] = '{
        '{ '{1, 0, 0, 0, 0, 0, 0}, '{default: 0}, '{default: 0}, '{default: 0},
           '{default: 0}, '{default: 0}, '{default: 0} },
        '{ '{1, -2, 0, 0, 0, 0, 0}, '{1, 2, 0, 0, 0, 0, 0}, '{default: 0},
           '{default: 0}, '{default: 0}, '{default: 0}, '{default: 0} },
        '{ '{1, -4, 4, 0, 0, 0, 0}, '{6, 0, -8, 0, 0, 0, 0}, '{1, 4, 4, 0, 0, 0, 0},
           '{default: 0}, '{default: 0}, '{default: 0}, '{default: 0} },
        '{ '{1, -6, 12, -8, 0, 0, 0}, '{23, -30, -12, 24, 0, 0, 0},
           '{23, 30, -12, -24, 0, 0, 0}, '{1, 6, 12, 8, 0, 0, 0},
           '{default: 0}, '{default: 0}, '{default: 0} },
        '{ '{1, -8, 24, -32, 16, 0, 0}, '{19, -44, 24, 16, -16, 0, 0},
           '{115, 0, -120, 0, 48, 0, 0}, '{19, 44, 24, -16, -16, 0, 0},
           '{1, 8, 24, 32, 16, 0, 0}, '{default: 0}, '{default: 0} },
        '{ '{1, -10, 40, -80, 80, -32, 0}, '{237, -750, 840, -240, -240, 160, 0},
           '{841, -770, -440, 560, 80, -160, 0}, '{841, 770, -440, -560, 80, 160, 0},
           '{237, 750, 840, 240, -240, -160, 0}, '{1, 10, 40, 80, 80, 32, 0},
           '{default: 0} },
        '{ '{1, -12, 60, -160, 240, -192, 64},
           '{361, -1416, 2220, -1600, 240, 384, -192},
           '{10543, -17340, 4740, 6880, -4080, -960, 960},
           '{5887, 0, -4620, 0, 1680, 0, -320},
           '{10543, 17340, 4740, -6880, -4080, 960, 960},
           '{361, 1416, 2220, 1600, 240, -384, -192},
           '{1, 12, 60, 160, 240, 192, 64} }
    };

    localparam int Divisors [7][7] = '{
        '{1, 1, 1, 1, 1, 1, 1},
        '{2, 2, 1, 1, 1, 1, 1},
        '{8, 8, 8, 1, 1, 1, 1},
        '{48, 48, 48, 48, 1, 1, 1},
        '{384, 96, 192, 96, 384, 1, 1},
        '{3840, 3840, 1920, 1920, 3840, 3840, 1},
        '{46080, 23040, 46080, 11520, 46080, 23040, 46080}
    };

    logic            aclk;
    logic            aresetn;
    logic [SW-1:0]   s_tdata;
    logic            s_tvalid;
    logic            s_tready;
    logic [MW-1:0]   m_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [2:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    bit              tx_gaps;
    bit              rx_stalls;
    longint          cycles;

    // round(a * b / 2^FRAC), halves away from zero
    function automatic longint scaled_product(longint a, longint b);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] p;
        logic        [127:0] mag;
        longint              r;
        bit                  neg;
        pa = a;
        pb = b;
        p = pa * pb;
        neg = p[127];
        mag = neg ? -p : p;
        mag = (mag + (128'd1 << (FRAC - 1))) >> FRAC;
        r = {1'b0, mag[62:0]};
        return neg ? -r : r;
    endfunction

    // returns {index_error, weight}
    function automatic logic [FRAC+1:0] assignment_weight(
        logic [2:0] ord,
        logic [2:0] idx,
        logic [FRAC:0] off
    );
        longint x;
        longint acc;
        longint d;
        longint w;
        if (ord == 3'd0 || ord > 3'(MAX_ORDER) || idx >= ord) begin
            return {1'b1, {(FRAC + 1){1'b0}}};
        end
        x = longint'($signed(off));
        if (x > (64'sd1 <<< (FRAC - 1))) x = 64'sd1 <<< (FRAC - 1);
        if (x < -(64'sd1 <<< (FRAC - 1))) x = -(64'sd1 <<< (FRAC - 1));
        acc = 0;
        for (int k = 6; k >= 0; k--) begin
            acc = (longint'(CoefRows[ord - 1][idx][k]) <<< FRAC) + scaled_product(x, acc);
        end
        d = Divisors[ord - 1][idx];
        if (acc <= 0) begin
            w = 0;
        end else begin
            w = (acc + d / 2) / d;
            if (w > (64'sd1 <<< FRAC)) w = 64'sd1 <<< FRAC;
        end
        return {1'b0, w[FRAC:0]};
    endfunction

    class weight_ledger;
        logic [2:0]      order;
        logic [FRAC+1:0] awaited[$];
        int              faults;

        function new();
            order = ASSIGN_ORDER_RESET;
            faults = 0;
        endfunction

        function void flag(string what, longint want, longint got);
            faults++;
            if (faults <= 10) begin
                $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
            end
        endfunction

        function void note_request(logic [2:0] idx, logic [FRAC:0] off);
            awaited.push_back(assignment_weight(order, idx, off));
        endfunction

        function void check_result(logic [MW-1:0] data);
            logic [FRAC+1:0] want;
            if (awaited.size() == 0) begin
                flag("unrequested weight", -1, data[FRAC:0]);
                return;
            end
            want = awaited.pop_front();
            if (data[FRAC:0] != want[FRAC:0]) flag("weight", want[FRAC:0], data[FRAC:0]);
            if (data[FRAC+1] != want[FRAC+1]) flag("index_error", want[FRAC+1], data[FRAC+1]);
        endfunction
    endclass

    weight_ledger ledger = new();

    charge_assignment_weight_unit #(.FRAC_BITS(FRAC)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            ledger.note_request(s_tdata[2:0], s_tdata[FRAC+3:3]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            ledger.check_result(m_tdata);
        end
    end

    initial begin
        int hold;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            hold = rx_stalls ? $urandom_range(0, 9) : 0;
            @(negedge aclk);
            if (hold > 0) begin
                m_tready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_request(logic [2:0] idx, logic [FRAC:0] off);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 9) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = SW'({off, idx});
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off until every weight is back, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (ledger.awaited.size() != 0) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
    endtask

    task automatic apb_access(bit wr, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_order(logic [2:0] ord);
        logic [31:0] readback;
        apb_access(1'b1, ORDER_ADDR, 32'(ord), readback);
        ledger.order = ord;
        apb_access(1'b0, ORDER_ADDR, 32'd0, readback);
        if (readback != 32'(ord)) ledger.flag("assign_order readback", ord, readback);
    endtask

    function automatic logic [FRAC:0] draw_offset();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) return (FRAC + 1)'($urandom_range(0, 1 << FRAC) - (1 << (FRAC - 1)));
        if (pick < 90) begin
            case ($urandom_range(0, 2))
                0: return (FRAC + 1)'(-(1 << (FRAC - 1)));
                1: return (FRAC + 1)'(1 << (FRAC - 1));
                default: return '0;
            endcase
        end
        return (FRAC + 1)'($urandom);
    endfunction

    initial begin
        logic [31:0] readback;
        logic [2:0]  ord;
        logic [2:0]  idx;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        cycles = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        apb_access(1'b0, ORDER_ADDR, 32'd0, readback);
        if (readback != 32'(ASSIGN_ORDER_RESET)) begin
            ledger.flag("assign_order reset value", ASSIGN_ORDER_RESET, readback);
        end

        // order one at reset: single point, stencil overrun, offsets past half a cell
        send_request(3'd0, (FRAC + 1)'(-(1 << (FRAC - 1))));
        send_request(3'd0, '0);
        send_request(3'd0, (FRAC + 1)'(1 << (FRAC - 1)));
        send_request(3'd1, '0);
        send_request(3'd7, (FRAC + 1)'(12345));
        send_request(3'd0, (FRAC + 1)'(-(1 << FRAC)));
        send_request(3'd0, (FRAC + 1)'((1 << FRAC) - 1));
        settle();

        // highest order: every point at both cell edges
        set_order(3'd7);
        for (int p = 0; p < 7; p++) begin
            send_request(3'(p), (FRAC + 1)'(-(1 << (FRAC - 1))));
            send_request(3'(p), (FRAC + 1)'(1 << (FRAC - 1)));
        end
        send_request(3'd3, '0);
        send_request(3'd7, (FRAC + 1)'(-1));
        send_request(3'd6, (FRAC + 1)'((1 << (FRAC - 1)) + 1));
        settle();

        for (int phase = 0; phase < 14; phase++) begin
            ord = (phase < 7) ? 3'(phase + 1) : 3'($urandom_range(1, 7));
            set_order(ord);
            tx_gaps = (phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_stalls = (phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n == 40 || $urandom_range(0, 299) == 0) settle();
                if ($urandom_range(0, 7) == 0) idx = 3'($urandom_range(0, 7));
                else idx = 3'($urandom_range(0, ord - 1));
                send_request(idx, draw_offset());
            end
            settle();
        end

        if (ledger.faults == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
